/* design/mge_pkg.sv */
// ----------------------------------------------------------------------------
// mge_pkg
// Types and fixed constants of the integer GEMM engine: command and mode
// codes, configuration register indexes, queue entry and back-end states.
// ----------------------------------------------------------------------------
package mge_pkg;

    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0]       MODE_ADD  = 2'd0;
    localparam logic [1:0]       MODE_MUL  = 2'd1;
    localparam logic [1:0]       MODE_MAC  = 2'd2;
    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_ROWS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_C_COLS = 3'd6;

    typedef enum logic [1:0] {
        CMD_LOAD_A = 2'd0,
        CMD_LOAD_B = 2'd1,
        CMD_LOAD_C = 2'd2,
        CMD_START  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]       mode;
        logic [DIM_W-1:0] a_rows;
        logic [DIM_W-1:0] a_cols;
        logic [DIM_W-1:0] b_rows;
        logic [DIM_W-1:0] b_cols;
        logic [DIM_W-1:0] c_rows;
        logic [DIM_W-1:0] c_cols;
    } cfg_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              bad;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_EMIT,
        ST_ERROR
    } st_t;

endpackage

/* design/mge_front.sv */
// ----------------------------------------------------------------------------
// mge_front
// Input classifier: drops out-of-range loads, checks the configured shape
// on a start beat and pushes the surviving beats into the command queue.
// ----------------------------------------------------------------------------
module mge_front
    import mge_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               cmd,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         col,
    input  logic signed [DATA_W-1:0] value,
    input  cfg_t                     cfg,
    input  logic                     q_full,
    output logic                     q_push,
    output q_entry_t                 q_data
);

    localparam logic [DIM_W:0] DIM_LIM = (DIM_W + 1)'(MAX_DIM);

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        dim_ok = (d != '0) && ({1'b0, d} <= DIM_LIM);
    endfunction

    function automatic logic in_bound(input logic [DIM_W-1:0] nr,
                                      input logic [DIM_W-1:0] nc);
        in_bound = (DIM_W'(row) < nr) && (DIM_W'(col) < nc) &&
                   ({1'b0, nr} <= DIM_LIM) && ({1'b0, nc} <= DIM_LIM);
    endfunction

    cmd_t cmd_code;
    logic shape_ok;
    logic keep;

    assign cmd_code = cmd_t'(cmd);

    always_comb
    begin
        shape_ok = 1'b0;
        if (dim_ok(cfg.a_rows) && dim_ok(cfg.a_cols) &&
            dim_ok(cfg.b_rows) && dim_ok(cfg.b_cols))
        begin
            unique case (cfg.mode)
                MODE_ADD: shape_ok = (cfg.a_rows == cfg.b_rows) &&
                                     (cfg.a_cols == cfg.b_cols);
                MODE_MUL: shape_ok = (cfg.a_cols == cfg.b_rows);
                MODE_MAC: shape_ok = (cfg.a_cols == cfg.b_rows) &&
                                     dim_ok(cfg.c_rows) && dim_ok(cfg.c_cols) &&
                                     (cfg.a_rows == cfg.c_rows) &&
                                     (cfg.b_cols == cfg.c_cols);
                default:  shape_ok = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd_code)
            CMD_LOAD_A: keep = in_bound(cfg.a_rows, cfg.a_cols);
            CMD_LOAD_B: keep = in_bound(cfg.b_rows, cfg.b_cols);
            CMD_LOAD_C: keep = in_bound(cfg.c_rows, cfg.c_cols);
            CMD_START:  keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    assign in_ready     = !q_full;
    assign q_push       = in_valid && !q_full && keep;
    assign q_data.cmd   = cmd_code;
    assign q_data.bad   = !shape_ok;
    assign q_data.row   = row;
    assign q_data.col   = col;
    assign q_data.value = value;

endmodule

/* design/mge_queue.sv */
// ----------------------------------------------------------------------------
// mge_queue
// Short command queue between the classifier and the compute back end.
// ----------------------------------------------------------------------------
module mge_queue
    import mge_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    input  logic     pop,
    output q_head_t  head,
    output logic     full
);

    q_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_pop;

    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/mge_back.sv */
// ----------------------------------------------------------------------------
// mge_back
// Element stores and compute sequencer: writes loads, walks the result
// matrix through a read / multiply-or-add / accumulate pipeline and drives the
// output register.
// ----------------------------------------------------------------------------
module mge_back
    import mge_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  q_head_t                  head,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [IDX_W-1:0]         out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic signed [DATA_W-1:0] result,
    output logic                     last,
    output logic                     error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = 2 * DIM_W + 2;

    function automatic logic [AW-1:0] addr_of(input logic [DIM_W-1:0] r,
                                              input logic [DIM_W-1:0] c);
        logic [FW-1:0] full_addr;
        full_addr = FW'(r) * FW'(MAX_DIM) + FW'(c);
        addr_of   = full_addr[AW-1:0];
    endfunction

    logic [DATA_W-1:0] a_mem [DEPTH];
    logic [DATA_W-1:0] b_mem [DEPTH];
    logic [DATA_W-1:0] c_mem [DEPTH];

    st_t              state_reg, state_next;
    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;

    logic              wr_a, wr_b, wr_c;
    logic [AW-1:0]     wr_addr;
    logic              issue;
    logic [AW-1:0]     a_addr, b_addr, c_addr;
    logic              is_add;
    logic              k_last, row_last, col_last;
    logic              out_free, load_out, load_err;

    logic [DATA_W-1:0] a_rd_reg, b_rd_reg, c_rd_reg;
    logic              s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [DATA_W-1:0] prod_reg, c2_reg;
    logic              s2_valid_reg, s2_first_reg, s2_last_reg;
    logic [DATA_W-1:0] acc_reg, c_init;
    logic              s3_done_reg;

    logic              out_valid_reg;
    logic [IDX_W-1:0]  out_row_reg, out_col_reg;
    logic [DATA_W-1:0] result_reg;
    logic              last_reg, error_reg;

    assign is_add   = (cfg.mode == MODE_ADD);
    assign k_last   = is_add || (({1'b0, k_reg} + (DIM_W + 1)'(1)) == {1'b0, cfg.a_cols});
    assign row_last = (({1'b0, i_reg} + (DIM_W + 1)'(1)) == {1'b0, cfg.a_rows});
    assign col_last = (({1'b0, j_reg} + (DIM_W + 1)'(1)) == {1'b0, cfg.b_cols});
    assign out_free = !out_valid_reg || out_ready;

    assign wr_addr = addr_of(DIM_W'(head.entry.row), DIM_W'(head.entry.col));
    assign a_addr  = addr_of(i_reg, is_add ? j_reg : k_reg);
    assign b_addr  = addr_of(is_add ? i_reg : k_reg, j_reg);
    assign c_addr  = addr_of(i_reg, j_reg);
    assign c_init  = (cfg.mode == MODE_MAC) ? c2_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        pop        = 1'b0;
        wr_a       = 1'b0;
        wr_b       = 1'b0;
        wr_c       = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        load_err   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    unique case (head.entry.cmd)
                        CMD_LOAD_A: wr_a = 1'b1;
                        CMD_LOAD_B: wr_b = 1'b1;
                        CMD_LOAD_C: wr_c = 1'b1;
                        CMD_START:
                        begin
                            i_next = '0;
                            j_next = '0;
                            k_next = '0;
                            state_next = head.entry.bad ? ST_ERROR : ST_ISSUE;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                issue = 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (s3_done_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (col_last)
                    begin
                        j_next = '0;
                        if (row_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_ISSUE;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    load_err   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_done_reg  <= s2_valid_reg && s2_last_reg;
            if (load_out || load_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_mem[wr_addr] <= head.entry.value;
        end
        if (wr_b)
        begin
            b_mem[wr_addr] <= head.entry.value;
        end
        if (wr_c)
        begin
            c_mem[wr_addr] <= head.entry.value;
        end
        if (issue)
        begin
            a_rd_reg <= a_mem[a_addr];
            b_rd_reg <= b_mem[b_addr];
            c_rd_reg <= c_mem[c_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= (k_reg == '0);
        s1_last_reg  <= k_last;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        c2_reg       <= c_rd_reg;
        prod_reg     <= is_add ? (a_rd_reg + b_rd_reg) : (a_rd_reg * b_rd_reg);
        if (s2_valid_reg)
        begin
            acc_reg <= (s2_first_reg ? c_init : acc_reg) + prod_reg;
        end
        if (load_out)
        begin
            out_row_reg <= i_reg[IDX_W-1:0];
            out_col_reg <= j_reg[IDX_W-1:0];
            result_reg  <= acc_reg;
            last_reg    <= row_last && col_last;
            error_reg   <= 1'b0;
        end
        else if (load_err)
        begin
            out_row_reg <= '0;
            out_col_reg <= '0;
            result_reg  <= '0;
            last_reg    <= 1'b1;
            error_reg   <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign result    = result_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

/* design/matrix_gemm_engine.sv */
// ----------------------------------------------------------------------------
// matrix_gemm_engine
// Integer matrix add / multiply / multiply-add engine with A, B and C stores.
// ----------------------------------------------------------------------------
// Load beats (cmd 0..2) produce no result; a load outside the configured
// size of its matrix is dropped. A start beat (cmd 3) computes A+B, A*B
// or A*B+C per the mode register and returns the result matrix row by
// row, last set on the final beat; a shape that does not fit the mode
// returns a single beat with error and last set. Each result element takes
// one store read per step of the inner sum through the single pipeline,
// then passes the read, product and accumulator registers before it is
// loaded into the output register. A four-entry command queue lets loads
// and starts be accepted while earlier work is still running; output
// stalls hold the sequencer. Configuration may only be written while the
// engine is idle.
module matrix_gemm_engine
    import mge_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               cmd,
    input  logic [IDX_W-1:0]         row,
    input  logic [IDX_W-1:0]         col,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [IDX_W-1:0]         out_row,
    output logic [IDX_W-1:0]         out_col,
    output logic signed [DATA_W-1:0] result,
    output logic                     last,
    output logic                     error
);

    cfg_t     cfg_reg;
    logic     q_full;
    logic     q_push;
    q_entry_t q_data;
    logic     q_pop;
    q_head_t  q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_MAC;
            cfg_reg.a_rows <= DIM_RESET;
            cfg_reg.a_cols <= DIM_RESET;
            cfg_reg.b_rows <= DIM_RESET;
            cfg_reg.b_cols <= DIM_RESET;
            cfg_reg.c_rows <= DIM_RESET;
            cfg_reg.c_cols <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:   cfg_reg.mode   <= cfg_data[1:0];
                REG_A_ROWS: cfg_reg.a_rows <= cfg_data;
                REG_A_COLS: cfg_reg.a_cols <= cfg_data;
                REG_B_ROWS: cfg_reg.b_rows <= cfg_data;
                REG_B_COLS: cfg_reg.b_cols <= cfg_data;
                REG_C_ROWS: cfg_reg.c_rows <= cfg_data;
                REG_C_COLS: cfg_reg.c_cols <= cfg_data;
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    mge_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .row      (row),
        .col      (col),
        .value    (value),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    mge_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full)
    );

    mge_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_row   (out_row),
        .out_col   (out_col),
        .result    (result),
        .last      (last),
        .error     (error)
    );

endmodule

/* design/mge_checker.sv */
// ----------------------------------------------------------------------------
// mge_checker
// Port-level checks on the result channel of the GEMM engine.
// ----------------------------------------------------------------------------
module mge_checker
    import mge_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [IDX_W-1:0]         out_row,
    input logic [IDX_W-1:0]         out_col,
    input logic signed [DATA_W-1:0] result,
    input logic                     last,
    input logic                     error
);

    logic [IDX_W-1:0] exp_row_reg, exp_row_next;
    logic [IDX_W-1:0] exp_col_reg, exp_col_next;
    logic [IDX_W-1:0] exp_row_inc;

    assign exp_row_inc = exp_row_reg + 3'd1;

    always_comb
    begin
        exp_row_next = exp_row_reg;
        exp_col_next = exp_col_reg;
        if (out_valid && out_ready)
        begin
            if (last)
            begin
                exp_row_next = '0;
                exp_col_next = '0;
            end
            else
            begin
                exp_row_next = out_row;
                exp_col_next = out_col + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_row_reg <= '0;
            exp_col_reg <= '0;
        end
        else
        begin
            exp_row_reg <= exp_row_next;
            exp_col_reg <= exp_col_next;
        end
    end

    // hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result) &&
        $stable(out_row) && $stable(out_col) && $stable(last) && $stable(error))
        else $error("result beat changed while stalled");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> last && (result == '0) && (out_row == '0) &&
        (out_col == '0))
        else $error("malformed error beat");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |->
        ((out_row == exp_row_reg) && (out_col == exp_col_reg)) ||
        ((out_row == exp_row_inc) && (out_col == '0)))
        else $error("result beat out of row-major order");

    a_start_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error && (exp_row_reg == '0) && (exp_col_reg == '0) |->
        (out_col == '0))
        else $error("run does not start at column zero");

endmodule

bind matrix_gemm_engine mge_checker u_mge_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_row   (out_row),
    .out_col   (out_col),
    .result    (result),
    .last      (last),
    .error     (error)
);
